### hw/rtl/ipfm_pkg.sv
// ipfm_pkg: types, codes and the prefix-to-mask function shared by the
// IPv4 first-match subnet filter. No dependencies.
`default_nettype none

package ipfm_pkg;

    localparam int ADDR_W     = 32;
    localparam int IDX_W      = 4;
    localparam int CNT_W      = 5;
    localparam int PLEN_W     = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FILTER_ENABLED = 3'd0,
        CFG_RULE_SET_VALID = 3'd1,
        CFG_KILL_SWITCH    = 3'd2,
        CFG_MISS_ALLOW     = 3'd3,
        CFG_RULE_COUNT     = 3'd4
    } ipfm_cfg_idx_t;

    typedef enum logic {
        REQ_RULE_WRITE = 1'b0,
        REQ_TEST       = 1'b1
    } ipfm_req_t;

    typedef struct packed {
        logic             filter_enabled;
        logic             rule_set_valid;
        logic             kill_switch;
        logic             miss_allow;
        logic [CNT_W-1:0] rule_count;
    } ipfm_cfg_t;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  index;
        logic [ADDR_W-1:0] network;
        logic [ADDR_W-1:0] mask;
        logic              exclude;
    } ipfm_rule_wr_t;

    // One address test travelling down the chain of rule cells
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr;
        logic              decided;
        logic              allow;
        logic              matched;
        logic [IDX_W-1:0]  idx;
    } ipfm_token_t;

    function automatic logic [ADDR_W-1:0] prefix_to_mask(input logic [PLEN_W-1:0] plen);
        logic [PLEN_W-1:0] p;
        p = (plen > PLEN_W'(ADDR_W)) ? PLEN_W'(ADDR_W) : plen;
        return ~({ADDR_W{1'b1}} >> p);
    endfunction

endpackage

`default_nettype wire

### hw/rtl/ipfm_cfg.sv
// ipfm_cfg: configuration register file of the subnet filter.
// Depends on ipfm_pkg.
`default_nettype none

module ipfm_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [ipfm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ipfm_pkg::CFG_DATA_W-1:0] cfg_data,
    output ipfm_pkg::ipfm_cfg_t                  cfg
);
    import ipfm_pkg::*;

    ipfm_cfg_t cfg_reg;
    ipfm_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_FILTER_ENABLED: cfg_next.filter_enabled = cfg_data[0];
                CFG_RULE_SET_VALID: cfg_next.rule_set_valid = cfg_data[0];
                CFG_KILL_SWITCH:    cfg_next.kill_switch    = cfg_data[0];
                CFG_MISS_ALLOW:     cfg_next.miss_allow     = cfg_data[0];
                CFG_RULE_COUNT:     cfg_next.rule_count     = cfg_data[CNT_W-1:0];
                default:            cfg_next = cfg_reg;  // unknown index: drop
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

endmodule

`default_nettype wire

### hw/rtl/ipfm_ctrl.sv
// ipfm_ctrl: request acceptance, busy tracking and token formation for the
// subnet filter; also turns rule writes into a broadcast to the cells.
// Depends on ipfm_pkg.
`default_nettype none

module ipfm_ctrl (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic                         req_type,
    input  wire logic [ipfm_pkg::IDX_W-1:0]   rule_index,
    input  wire logic [ipfm_pkg::ADDR_W-1:0]  rule_network,
    input  wire logic [ipfm_pkg::PLEN_W-1:0]  rule_prefix_len,
    input  wire logic                         rule_exclude,
    input  wire logic [ipfm_pkg::ADDR_W-1:0]  test_address,
    input  wire ipfm_pkg::ipfm_cfg_t          cfg,
    input  wire ipfm_pkg::ipfm_token_t        tok_last,
    output ipfm_pkg::ipfm_token_t             tok_first,
    output ipfm_pkg::ipfm_rule_wr_t           rule_wr
);
    import ipfm_pkg::*;

    logic busy_reg;
    logic busy_next;
    logic accept;
    logic test_accept;

    // the test whose verdict leaves the chain this cycle no longer blocks
    assign busy        = busy_reg & ~tok_last.valid;
    assign accept      = start & ~busy;
    assign test_accept = accept & (ipfm_req_t'(req_type) == REQ_TEST);

    always_comb
    begin
        busy_next = busy_reg;
        if (test_accept)
            busy_next = 1'b1;
        else if (tok_last.valid)
            busy_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= busy_next;
    end

    always_comb
    begin
        rule_wr.en      = accept & (ipfm_req_t'(req_type) == REQ_RULE_WRITE);
        rule_wr.index   = rule_index;
        rule_wr.network = rule_network;
        rule_wr.mask    = prefix_to_mask(rule_prefix_len);
        rule_wr.exclude = rule_exclude;
    end

    // settle the overriding cases at entry; the cells then leave them alone
    always_comb
    begin
        tok_first.valid   = test_accept;
        tok_first.addr    = test_address;
        tok_first.matched = 1'b0;
        tok_first.idx     = '0;
        if (!cfg.filter_enabled)
        begin
            tok_first.decided = 1'b1;
            tok_first.allow   = 1'b1;
        end
        else if (!cfg.rule_set_valid || cfg.kill_switch)
        begin
            tok_first.decided = 1'b1;
            tok_first.allow   = 1'b0;
        end
        else
        begin
            tok_first.decided = 1'b0;
            tok_first.allow   = cfg.miss_allow;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/ipfm_cell.sv
// ipfm_cell: one rule entry of the filter chain; holds network, mask and
// exclude bit and registers the passing test token. Depends on ipfm_pkg.
`default_nettype none

module ipfm_cell #(
    parameter int CELL_ID = 0
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire ipfm_pkg::ipfm_rule_wr_t     rule_wr,
    input  wire logic [ipfm_pkg::CNT_W-1:0]  rule_count,
    input  wire ipfm_pkg::ipfm_token_t       tok_in,
    output ipfm_pkg::ipfm_token_t            tok_out
);
    import ipfm_pkg::*;

    localparam logic             WRITABLE = (CELL_ID < (1 << IDX_W));
    localparam logic [IDX_W-1:0] MY_IDX   = IDX_W'(CELL_ID % (1 << IDX_W));

    logic [ADDR_W-1:0] network_reg;
    logic [ADDR_W-1:0] mask_reg;
    logic              exclude_reg;
    ipfm_token_t       tok_reg;
    ipfm_token_t       tok_next;
    logic              in_use;
    logic              hit;

    assign tok_out = tok_reg;
    assign in_use  = ({{(32-CNT_W){1'b0}}, rule_count} > 32'(CELL_ID));
    assign hit     = in_use && ((tok_in.addr & mask_reg) == network_reg);

    always_ff @(posedge clk)
    begin
        if (WRITABLE && rule_wr.en && (rule_wr.index == MY_IDX))
        begin
            network_reg <= rule_wr.network;
            mask_reg    <= rule_wr.mask;
            exclude_reg <= rule_wr.exclude;
        end
    end

    always_comb
    begin
        tok_next = tok_in;
        if (!tok_in.decided && hit)
        begin
            tok_next.decided = 1'b1;
            tok_next.allow   = ~exclude_reg;
            tok_next.matched = 1'b1;
            tok_next.idx     = MY_IDX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_reg <= '0;
        else
            tok_reg <= tok_next;
    end

endmodule

`default_nettype wire

### hw/rtl/ipv4_first_match_subnet_filter_core.sv
// ipv4_first_match_subnet_filter_core: top level of the IPv4 first-match
// subnet filter. Depends on ipfm_pkg, ipfm_cfg, ipfm_ctrl and ipfm_cell.
//
// Channel   Handshake                    Payload
// request   start, busy (take: start&!busy) req_type, rule_*, test_address
// result    result_valid (one cycle)     allow, matched, match_index
// config    cfg_valid, cfg_ready         cfg_index, cfg_data
//
// An address test walks the chain of MAX_RULES rule cells, one cell per
// cycle, and busy stays high from acceptance until its verdict appears, so
// a new test is taken only once the previous verdict leaves the chain.
// A rule write gives no result and leaves busy low.
// Reset clears configuration and the chain; rule entries hold garbage until
// written. Results cannot be stalled; cfg_ready is always high.
`default_nettype none

module ipv4_first_match_subnet_filter_core #(
    parameter int MAX_RULES = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic                           req_type,
    input  wire logic [ipfm_pkg::IDX_W-1:0]      rule_index,
    input  wire logic [ipfm_pkg::ADDR_W-1:0]     rule_network,
    input  wire logic [ipfm_pkg::PLEN_W-1:0]     rule_prefix_len,
    input  wire logic                           rule_exclude,
    input  wire logic [ipfm_pkg::ADDR_W-1:0]     test_address,
    output logic                                result_valid,
    output logic                                allow,
    output logic                                matched,
    output logic [ipfm_pkg::IDX_W-1:0]           match_index,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [ipfm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ipfm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ipfm_pkg::*;

    ipfm_cfg_t     cfg;
    ipfm_rule_wr_t rule_wr;
    ipfm_token_t   tok [MAX_RULES+1];

    ipfm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ipfm_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .req_type        (req_type),
        .rule_index      (rule_index),
        .rule_network    (rule_network),
        .rule_prefix_len (rule_prefix_len),
        .rule_exclude    (rule_exclude),
        .test_address    (test_address),
        .cfg             (cfg),
        .tok_last        (tok[MAX_RULES]),
        .tok_first       (tok[0]),
        .rule_wr         (rule_wr)
    );

    for (genvar i = 0; i < MAX_RULES; i++)
    begin : g_cell
        ipfm_cell #(
            .CELL_ID (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .rule_wr    (rule_wr),
            .rule_count (cfg.rule_count),
            .tok_in     (tok[i]),
            .tok_out    (tok[i+1])
        );
    end

    assign result_valid = tok[MAX_RULES].valid;
    assign allow        = tok[MAX_RULES].allow;
    assign matched      = tok[MAX_RULES].matched;
    assign match_index  = tok[MAX_RULES].idx;

endmodule

`default_nettype wire

### sim/ipfm_verdict_checker.sv
// ipfm_verdict_checker: watches the request, config and result channels of the
// IPv4 first-match subnet filter, predicts each verdict and compares it.
// Depends on ipfm_pkg.
`timescale 1ns / 1ps

module ipfm_verdict_checker #(
    parameter int MAX_RULES = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  logic                           req_type,
    input  logic [ipfm_pkg::IDX_W-1:0]      rule_index,
    input  logic [ipfm_pkg::ADDR_W-1:0]     rule_network,
    input  logic [ipfm_pkg::PLEN_W-1:0]     rule_prefix_len,
    input  logic                           rule_exclude,
    input  logic [ipfm_pkg::ADDR_W-1:0]     test_address,
    input  logic                           result_valid,
    input  logic                           allow,
    input  logic                           matched,
    input  logic [ipfm_pkg::IDX_W-1:0]      match_index,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [ipfm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ipfm_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             pending,
    output int                             mismatches
);

    import ipfm_pkg::*;

    typedef struct packed {
        logic             allow;
        logic             matched;
        logic [IDX_W-1:0] idx;
    } verdict_t;

    verdict_t          pending_verdicts[$];
    logic [ADDR_W-1:0] net_tab  [MAX_RULES];
    logic [ADDR_W-1:0] mask_tab [MAX_RULES];
    logic              excl_tab [MAX_RULES];
    ipfm_cfg_t         cfg_shadow;

    function automatic logic [ADDR_W-1:0] leading_ones(input logic [PLEN_W-1:0] plen);
        int p;
        p = (plen > 6'd32) ? 32 : int'(plen);
        if (p == 0)
            return '0;
        return {ADDR_W{1'b1}} << (ADDR_W - p);
    endfunction

    function automatic verdict_t lookup_verdict(input logic [ADDR_W-1:0] addr);
        verdict_t v;
        int       n;
        bit       hit;
        v   = '0;
        hit = 1'b0;
        if (!cfg_shadow.filter_enabled)
            v.allow = 1'b1;
        else if (!cfg_shadow.rule_set_valid || cfg_shadow.kill_switch)
            v.allow = 1'b0;
        else
        begin
            n = (cfg_shadow.rule_count > MAX_RULES) ? MAX_RULES : int'(cfg_shadow.rule_count);
            v.allow = cfg_shadow.miss_allow;
            // first hit in table order decides
            for (int i = 0; i < n && !hit; i++)
            begin
                if ((addr & mask_tab[i]) == net_tab[i])
                begin
                    v.allow   = !excl_tab[i];
                    v.matched = 1'b1;
                    v.idx     = IDX_W'(i);
                    hit       = 1'b1;
                end
            end
        end
        return v;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("%0t ns: verdict mismatch: %s", $time, what);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t want;
        if (!rst_n)
        begin
            cfg_shadow = '0;
            pending_verdicts.delete();
            pending    = 0;
            mismatches = 0;
            for (int i = 0; i < MAX_RULES; i++)
            begin
                net_tab[i]  = '0;
                mask_tab[i] = '0;
                excl_tab[i] = 1'b0;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (ipfm_cfg_idx_t'(cfg_index))
                    CFG_FILTER_ENABLED: cfg_shadow.filter_enabled = cfg_data[0];
                    CFG_RULE_SET_VALID: cfg_shadow.rule_set_valid = cfg_data[0];
                    CFG_KILL_SWITCH:    cfg_shadow.kill_switch    = cfg_data[0];
                    CFG_MISS_ALLOW:     cfg_shadow.miss_allow     = cfg_data[0];
                    CFG_RULE_COUNT:     cfg_shadow.rule_count     = cfg_data;
                    default: ;
                endcase
            end

            // retire the oldest verdict before taking a new request
            if (result_valid)
            begin
                if (pending_verdicts.size() == 0)
                    report_mismatch("result with no test request outstanding");
                else
                begin
                    want = pending_verdicts.pop_front();
                    if (allow !== want.allow)
                        report_mismatch($sformatf("allow %b, expected %b", allow, want.allow));
                    if (matched !== want.matched)
                        report_mismatch($sformatf("matched %b, expected %b",
                                                  matched, want.matched));
                    if (match_index !== want.idx)
                        report_mismatch($sformatf("match_index %0d, expected %0d",
                                                  match_index, want.idx));
                end
            end

            if (start && !busy)
            begin
                if (req_type == REQ_RULE_WRITE)
                begin
                    if (rule_index < MAX_RULES)
                    begin
                        net_tab[rule_index]  = rule_network;
                        mask_tab[rule_index] = leading_ones(rule_prefix_len);
                        excl_tab[rule_index] = rule_exclude;
                    end
                end
                else
                    pending_verdicts.push_back(lookup_verdict(test_address));
            end

            pending = pending_verdicts.size();
        end
    end

endmodule

### sim/tb_ipv4_first_match_subnet_filter_core.sv
// tb_ipv4_first_match_subnet_filter_core: drives rule writes, address tests and
// register writes into the subnet filter and gives the verdict.
// Depends on ipfm_pkg, ipv4_first_match_subnet_filter_core and ipfm_verdict_checker.
`timescale 1ns / 1ps

module tb_ipv4_first_match_subnet_filter_core;

    import ipfm_pkg::*;

    localparam int RULES       = 16;
    localparam int GAP_PCT     = 30;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 50;
    localparam int CYCLE_LIMIT = 200_000;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic                  req_type;
    logic [IDX_W-1:0]      rule_index;
    logic [ADDR_W-1:0]     rule_network;
    logic [PLEN_W-1:0]     rule_prefix_len;
    logic                  rule_exclude;
    logic [ADDR_W-1:0]     test_address;
    logic                  result_valid;
    logic                  allow;
    logic                  matched;
    logic [IDX_W-1:0]      match_index;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int                    pending;
    int                    mismatches;
    int                    cycle_count;
    bit                    no_idle;
    logic                  req_taken = 1'b0;
    logic                  cfg_taken = 1'b0;

    // what the table holds, used to aim test addresses at rules and to reuse networks
    logic [ADDR_W-1:0]     net_sh  [RULES];
    logic [PLEN_W-1:0]     plen_sh [RULES];

    always #5 clk = ~clk;

    ipv4_first_match_subnet_filter_core #(
        .MAX_RULES(RULES)
    ) DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .req_type        (req_type),
        .rule_index      (rule_index),
        .rule_network    (rule_network),
        .rule_prefix_len (rule_prefix_len),
        .rule_exclude    (rule_exclude),
        .test_address    (test_address),
        .result_valid    (result_valid),
        .allow           (allow),
        .matched         (matched),
        .match_index     (match_index),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    ipfm_verdict_checker #(
        .MAX_RULES(RULES)
    ) u_verdict_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .req_type        (req_type),
        .rule_index      (rule_index),
        .rule_network    (rule_network),
        .rule_prefix_len (rule_prefix_len),
        .rule_exclude    (rule_exclude),
        .test_address    (test_address),
        .result_valid    (result_valid),
        .allow           (allow),
        .matched         (matched),
        .match_index     (match_index),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .pending         (pending),
        .mismatches      (mismatches)
    );

    // handshake outcome at each rising edge, read back at the falling edge
    always @(posedge clk)
    begin
        req_taken <= start && !busy;
        cfg_taken <= cfg_valid && cfg_ready;
    end

    function automatic logic [ADDR_W-1:0] span_mask(input logic [PLEN_W-1:0] plen);
        int          p;
        logic [32:0] host_span;
        p = (plen > 6'd32) ? 32 : int'(plen);
        host_span = (33'd1 << (32 - p)) - 33'd1;
        return ~host_span[31:0];
    endfunction

    // address inside the subnet of one of the first 'span' entries
    function automatic logic [ADDR_W-1:0] aim_address(input int span);
        int                k;
        logic [ADDR_W-1:0] m;
        k = $urandom_range(0, span - 1);
        m = span_mask(plen_sh[k]);
        return (net_sh[k] & m) | ($urandom() & ~m);
    endfunction

    task automatic send_item(input ipfm_req_t kind, input logic [IDX_W-1:0] idx,
                             input logic [ADDR_W-1:0] net, input logic [PLEN_W-1:0] plen,
                             input logic excl, input logic [ADDR_W-1:0] addr);
        while (!no_idle && $urandom_range(0, 99) < GAP_PCT)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start           <= 1'b1;
        req_type        <= kind;
        rule_index      <= idx;
        rule_network    <= net;
        rule_prefix_len <= plen;
        rule_exclude    <= excl;
        test_address    <= addr;
        do
            @(negedge clk);
        while (!req_taken);
        if (kind == REQ_RULE_WRITE)
        begin
            net_sh[idx]  = net;
            plen_sh[idx] = plen;
        end
    endtask

    task automatic send_rule(input logic [IDX_W-1:0] idx, input logic [ADDR_W-1:0] net,
                             input logic [PLEN_W-1:0] plen, input logic excl);
        send_item(REQ_RULE_WRITE, idx, net, plen, excl, $urandom());
    endtask

    task automatic send_test(input logic [ADDR_W-1:0] addr);
        send_item(REQ_TEST, IDX_W'($urandom_range(0, 15)), $urandom(),
                  PLEN_W'($urandom_range(0, 63)), 1'($urandom_range(0, 1)), addr);
    endtask

    task automatic write_reg(input ipfm_cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        while (!no_idle && $urandom_range(0, 99) < GAP_PCT)
        begin
            cfg_valid <= 1'b0;
            @(negedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(negedge clk);
        while (!cfg_taken);
    endtask

    // hold requests until every verdict is back and the chain has emptied
    task automatic drain();
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (RULES + 4) @(negedge clk);
    endtask

    task automatic configure(input bit en, input bit valid, input bit kill, input bit dflt,
                             input logic [CFG_DATA_W-1:0] count);
        drain();
        // upper data bits of the one-bit registers carry noise
        write_reg(CFG_FILTER_ENABLED, {4'($urandom_range(0, 15)), en});
        write_reg(CFG_RULE_SET_VALID, {4'($urandom_range(0, 15)), valid});
        write_reg(CFG_KILL_SWITCH,    {4'($urandom_range(0, 15)), kill});
        write_reg(CFG_MISS_ALLOW,     {4'($urandom_range(0, 15)), dflt});
        write_reg(CFG_RULE_COUNT,     count);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        bit                    en, valid, kill, dflt;
        logic [CFG_DATA_W-1:0] count;
        int                    in_use;
        logic [PLEN_W-1:0]     plen;
        logic [ADDR_W-1:0]     net;
        logic [ADDR_W-1:0]     addr;

        rst_n           = 1'b0;
        start           = 1'b0;
        req_type        = 1'b0;
        rule_index      = '0;
        rule_network    = '0;
        rule_prefix_len = '0;
        rule_exclude    = 1'b0;
        test_address    = '0;
        cfg_valid       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        no_idle         = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // filtering off after reset: everything passes
        send_test(32'h0000_0000);
        send_test(32'hFFFF_FFFF);
        // no rule set loaded, then kill switch
        configure(1'b1, 1'b0, 1'b0, 1'b0, 5'd0);
        send_test($urandom());
        configure(1'b1, 1'b1, 1'b1, 1'b0, 5'd0);
        send_test($urandom());
        // empty table: default policy
        configure(1'b1, 1'b1, 1'b0, 1'b1, 5'd0);
        send_test(32'h0A00_0001);

        send_rule(4'd0, 32'h0A00_0000, 6'd8,  1'b0);
        send_rule(4'd1, 32'hC0A8_0100, 6'd24, 1'b1);
        send_rule(4'd2, 32'hFFFF_FFFF, 6'd32, 1'b1);
        send_rule(4'd3, 32'h1234_5678, 6'd40, 1'b0);  // prefix above 32 saturates
        send_rule(4'd4, 32'h0A00_00FF, 6'd8,  1'b1);  // host bits set, never matches
        send_rule(4'd5, 32'h8000_0000, 6'd63, 1'b1);
        for (int i = 6; i < 15; i++)
        begin
            plen = PLEN_W'($urandom_range(1, 31));
            send_rule(IDX_W'(i), $urandom() & span_mask(plen), plen,
                      1'($urandom_range(0, 1)));
        end
        send_rule(4'd15, 32'h0000_0000, 6'd0, 1'b0);  // catch-all

        configure(1'b1, 1'b1, 1'b0, 1'b0, 5'd16);
        send_test(32'h0A01_0203);
        send_test(32'hC0A8_0107);
        send_test(32'hFFFF_FFFF);
        send_test(32'h1234_5678);
        send_test(32'h8000_0000);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            en    = 1'b1;
            valid = 1'b1;
            kill  = ($urandom_range(0, 9) == 0);
            dflt  = 1'($urandom_range(0, 1));
            count = ($urandom_range(0, 9) == 0) ? CFG_DATA_W'($urandom_range(17, 31))
                                                : CFG_DATA_W'($urandom_range(0, 16));
            case (ph)
                0: begin kill = 1'b0; dflt = 1'b0; count = 5'd16; end
                1: begin kill = 1'b0; dflt = 1'b1; count = 5'd1; end
                2: begin kill = 1'b0; count = 5'd0; end
                3: begin kill = 1'b0; count = 5'd31; end
                4: en = 1'b0;
                5: kill = 1'b1;
                6: valid = 1'b0;
                default:
                begin
                    en    = ($urandom_range(0, 9) != 0);
                    valid = ($urandom_range(0, 9) != 0);
                end
            endcase
            no_idle = (ph == 3);
            configure(en, valid, kill, dflt, count);
            in_use = (count > RULES) ? RULES : int'(count);

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 49) == 0)
                    drain();
                if ($urandom_range(0, 3) == 0)
                begin
                    case ($urandom_range(0, 9))
                        0:       plen = PLEN_W'($urandom_range(33, 63));
                        1:       plen = 6'd0;
                        2:       plen = 6'd32;
                        default: plen = PLEN_W'($urandom_range(1, 31));
                    endcase
                    case ($urandom_range(0, 9))
                        0, 1:    net = $urandom();
                        2, 3:    net = net_sh[$urandom_range(0, RULES - 1)] & span_mask(plen);
                        default: net = $urandom() & span_mask(plen);
                    endcase
                    send_rule(IDX_W'($urandom_range(0, RULES - 1)), net, plen,
                              1'($urandom_range(0, 1)));
                end
                else
                begin
                    if (in_use > 0 && $urandom_range(0, 9) < 7)
                        addr = aim_address(in_use);
                    else
                    begin
                        case ($urandom_range(0, 5))
                            0:       addr = 32'h0000_0000;
                            1:       addr = 32'hFFFF_FFFF;
                            default: addr = $urandom();
                        endcase
                    end
                    send_test(addr);
                end
            end
        end
        no_idle = 1'b0;

        drain();
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### files.f
hw/rtl/ipfm_pkg.sv
hw/rtl/ipfm_cfg.sv
hw/rtl/ipfm_ctrl.sv
hw/rtl/ipfm_cell.sv
hw/rtl/ipv4_first_match_subnet_filter_core.sv
sim/ipfm_verdict_checker.sv
sim/tb_ipv4_first_match_subnet_filter_core.sv
